@@ hdl/urs_pkg.sv @@
// Shared types and constants for the ultrasonic ranging and steering block.
// No dependencies; every other file refers to this package by scoped names.
`timescale 1ns / 1ps
`default_nettype none
package urs_pkg;

  localparam int DIST_W = 11;
  localparam int CAP_W  = 16;
  localparam int SEL_W  = 2;
  localparam int MODE_W = 3;
  localparam int CFG_IDX_W = 2;

  typedef logic [DIST_W-1:0] dist_t;
  typedef logic [SEL_W-1:0]  sel_t;

  // Sensor codes of the round-robin pointer.
  localparam sel_t SENS_RIGHT = 2'd0;
  localparam sel_t SENS_LEFT  = 2'd1;
  localparam sel_t SENS_FRONT = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_FRONT_THR  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SIDE_THR   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TURN_THR   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SIDE_MARG  = 2'd3;

  // Reset values.
  localparam dist_t FRONT_THR_RST = 11'd30;
  localparam dist_t SIDE_THR_RST  = 11'd20;
  localparam dist_t TURN_THR_RST  = 11'd50;
  localparam dist_t SIDE_MARG_RST = 11'd5;

  // Echo width to centimetres: floor(w/58) = floor(floor(w/2) * RECIP_29 / 2^24).
  // Exact for floor(w/2) below 64280; larger widths saturate first.
  localparam int    ECHO_DIVISOR = 58;
  localparam int    SAT_LIMIT    = (1 << DIST_W) * ECHO_DIVISOR;
  localparam int    HALF_W       = 16;
  localparam int    RECIP_W      = 20;
  localparam int    RECIP_SHIFT  = 24;
  localparam logic [RECIP_W-1:0] RECIP_29 = 20'd578525;
  localparam dist_t DIST_MAX     = '1;

  typedef struct packed {
    dist_t front_thr;
    dist_t side_thr;
    dist_t turn_thr;
    dist_t side_marg;
  } cfg_t;

  // One decoded echo event for the steering logic.
  typedef struct packed {
    logic  tick;
    logic  fall;
    dist_t range_cm;
  } echo_evt_t;

  typedef struct packed {
    logic              trigger_pulse;
    sel_t              sensor_select;
    logic              left_wheel_reverse;
    logic              right_wheel_reverse;
    logic [MODE_W-1:0] drive_mode;
    dist_t             front_range;
    dist_t             left_range;
    dist_t             right_range;
  } result_t;

endpackage
`default_nettype wire

@@ hdl/urs_in_if.sv @@
// Input request channel: scan ticks and echo-edge capture times.
// Depends on urs_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none
interface urs_in_if;
  logic                        valid;
  logic                        ready;
  logic                        mode;
  logic [urs_pkg::CAP_W-1:0]   capture_time;

  modport source (output valid, output mode, output capture_time, input ready);
  modport sink   (input valid, input mode, input capture_time, output ready);
endinterface
`default_nettype wire

@@ hdl/urs_out_if.sv @@
// Result request channel: trigger, sensor select, wheel and range status.
// Depends on urs_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none
interface urs_out_if;
  logic                         valid;
  logic                         ready;
  logic                         trigger_pulse;
  logic [urs_pkg::SEL_W-1:0]    sensor_select;
  logic                         left_wheel_reverse;
  logic                         right_wheel_reverse;
  logic [urs_pkg::MODE_W-1:0]   drive_mode;
  logic [urs_pkg::DIST_W-1:0]   front_range;
  logic [urs_pkg::DIST_W-1:0]   left_range;
  logic [urs_pkg::DIST_W-1:0]   right_range;

  modport source (output valid, output trigger_pulse, output sensor_select,
                  output left_wheel_reverse, output right_wheel_reverse,
                  output drive_mode, output front_range, output left_range,
                  output right_range, input ready);
  modport sink   (input valid, input trigger_pulse, input sensor_select,
                  input left_wheel_reverse, input right_wheel_reverse,
                  input drive_mode, input front_range, input left_range,
                  input right_range, output ready);
endinterface
`default_nettype wire

@@ hdl/urs_ranger.sv @@
// Echo edge tracker: keeps the rising stamp and turns an echo width into cm.
// Depends on urs_pkg.
`timescale 1ns / 1ps
`default_nettype none
module urs_ranger #(
  parameter int TIMER_WIDTH = 16
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        step,
  input  wire logic                        mode,
  input  wire logic [urs_pkg::CAP_W-1:0]   capture_time,
  output urs_pkg::echo_evt_t               evt
);

  localparam int WW = (TIMER_WIDTH > 17) ? TIMER_WIDTH : 17;
  localparam int PROD_W = urs_pkg::HALF_W + urs_pkg::RECIP_W;

  logic                   awaiting_fall_r;
  logic [TIMER_WIDTH-1:0] rise_stamp_r;
  logic [TIMER_WIDTH-1:0] cap_tw;
  logic [TIMER_WIDTH-1:0] width;
  logic [WW-1:0]          width_w;
  logic                   sat;
  logic [PROD_W-1:0]      prod;

  assign cap_tw  = TIMER_WIDTH'(capture_time);
  assign width   = cap_tw - rise_stamp_r;
  assign width_w = WW'(width);
  assign sat     = (width_w >= WW'(urs_pkg::SAT_LIMIT));
  assign prod    = PROD_W'(width_w[urs_pkg::HALF_W:1]) * PROD_W'(urs_pkg::RECIP_29);

  always_comb begin
    evt.tick     = ~mode;
    evt.fall     = mode & awaiting_fall_r;
    evt.range_cm = sat ? urs_pkg::DIST_MAX
                       : prod[urs_pkg::RECIP_SHIFT +: urs_pkg::DIST_W];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      awaiting_fall_r <= 1'b0;
      rise_stamp_r    <= '0;
    end else if (step && mode) begin
      if (!awaiting_fall_r) begin
        rise_stamp_r <= cap_tw;
      end
      awaiting_fall_r <= ~awaiting_fall_r;
    end
  end

endmodule
`default_nettype wire

@@ hdl/urs_steer.sv @@
// Sensor pointer, stored distances and the drive-mode state machine.
// Depends on urs_pkg; gives the result of the current event combinationally.
`timescale 1ns / 1ps
`default_nettype none
module urs_steer (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                step,
  input  wire urs_pkg::echo_evt_t  evt,
  input  wire urs_pkg::cfg_t       cfg,
  output urs_pkg::result_t         res
);

  typedef enum logic [urs_pkg::MODE_W-1:0] {
    DM_CRUISE  = 3'd0,
    DM_MEAS_R  = 3'd1,
    DM_MEAS_L  = 3'd2,
    DM_TURN_R  = 3'd3,
    DM_TURN_L  = 3'd4,
    DM_AVOID_R = 3'd5,
    DM_AVOID_L = 3'd6
  } drive_t;

  drive_t          state_r, state_nxt;
  urs_pkg::sel_t   ptr_r, ptr_nxt;
  urs_pkg::dist_t  front_r, front_nxt;
  urs_pkg::dist_t  left_r, left_nxt;
  urs_pkg::dist_t  right_r, right_nxt;
  urs_pkg::dist_t  release_lvl;
  logic            trig;
  logic            st_right, st_left;

  assign release_lvl = (cfg.side_thr > cfg.side_marg) ? cfg.side_thr - cfg.side_marg : '0;

  always_comb begin
    trig      = 1'b0;
    st_right  = 1'b0;
    st_left   = 1'b0;
    ptr_nxt   = ptr_r;
    front_nxt = front_r;
    left_nxt  = left_r;
    right_nxt = right_r;
    state_nxt = state_r;

    if (evt.tick) begin
      trig = (ptr_r <= urs_pkg::SENS_FRONT);
    end else if (evt.fall) begin
      unique case (ptr_r)
        urs_pkg::SENS_RIGHT: begin
          right_nxt = evt.range_cm;
          ptr_nxt   = urs_pkg::SENS_LEFT;
          st_right  = 1'b1;
        end
        urs_pkg::SENS_LEFT: begin
          left_nxt = evt.range_cm;
          ptr_nxt  = urs_pkg::SENS_FRONT;
          st_left  = 1'b1;
        end
        urs_pkg::SENS_FRONT: begin
          front_nxt = evt.range_cm;
          ptr_nxt   = urs_pkg::SENS_RIGHT;
        end
        default: ;
      endcase
    end

    unique case (state_r)
      DM_MEAS_R: begin
        if (st_right) begin
          state_nxt = DM_MEAS_L;
          trig      = 1'b1;
        end
      end
      DM_MEAS_L: begin
        if (st_left) begin
          state_nxt = (right_nxt > left_nxt) ? DM_TURN_R : DM_TURN_L;
        end
      end
      DM_TURN_R, DM_TURN_L: begin
        if (front_nxt >= cfg.turn_thr) begin
          state_nxt = DM_CRUISE;
          left_nxt  = cfg.side_thr;
          right_nxt = cfg.side_thr;
        end
      end
      DM_AVOID_R: begin
        if (left_nxt >= release_lvl) state_nxt = DM_CRUISE;
      end
      DM_AVOID_L: begin
        if (right_nxt >= release_lvl) state_nxt = DM_CRUISE;
      end
      default: begin
        state_nxt = DM_CRUISE;
        if (front_nxt < cfg.front_thr) begin
          state_nxt = DM_MEAS_R;
          ptr_nxt   = urs_pkg::SENS_RIGHT;
          trig      = 1'b1;
        end else if (left_nxt < cfg.side_thr) begin
          state_nxt = DM_AVOID_R;
        end else if (right_nxt < cfg.side_thr) begin
          state_nxt = DM_AVOID_L;
        end
      end
    endcase

    res.trigger_pulse       = trig;
    res.sensor_select       = ptr_nxt;
    res.left_wheel_reverse  = (state_nxt == DM_TURN_L) || (state_nxt == DM_AVOID_L);
    res.right_wheel_reverse = (state_nxt == DM_TURN_R) || (state_nxt == DM_AVOID_R);
    res.drive_mode          = state_nxt;
    res.front_range         = front_nxt;
    res.left_range          = left_nxt;
    res.right_range         = right_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= DM_CRUISE;
      ptr_r   <= urs_pkg::SENS_FRONT;
      front_r <= urs_pkg::FRONT_THR_RST;
      left_r  <= urs_pkg::SIDE_THR_RST;
      right_r <= urs_pkg::SIDE_THR_RST;
    end else if (step) begin
      state_r <= state_nxt;
      ptr_r   <= ptr_nxt;
      front_r <= front_nxt;
      left_r  <= left_nxt;
      right_r <= right_nxt;
    end
  end

endmodule
`default_nettype wire

@@ hdl/ultrasonic_ranging_obstacle_steering.sv @@
// Top level of the ultrasonic ranging and obstacle steering block.
// Depends on urs_pkg, urs_in_if, urs_out_if, urs_ranger and urs_steer.
//
// Usage:
//   in_chan carries one request per event: mode 0 is a scan tick, mode 1 an
//   echo edge with the timer value latched at that edge. Edges alternate
//   rising/falling; a falling edge turns the echo width into centimetres for
//   the sensor under the round-robin pointer (right, left, front).
//   out_chan returns exactly one result request per input request: trigger
//   and sensor select, wheel reverse lines, drive mode and the three ranges.
//   cfg_we/cfg_index/cfg_data write the four thresholds; write them only
//   while no request is in flight.
// Timing:
//   A request lands in the input register, then one pass of steering logic
//   (echo width, divide by 58 through a reciprocal multiply, state update)
//   loads the result register. Throughput is one request per cycle while
//   out_chan.ready stays high.
// Reset:
//   rst_n (synchronous) empties both registers and restores thresholds,
//   ranges, the pointer (front) and cruise mode. No clearing pass.
// Stall:
//   While out_chan.ready is low the result holds; the input register still
//   takes one more request, then in_chan.ready drops until the result moves.
`timescale 1ns / 1ps
`default_nettype none
module ultrasonic_ranging_obstacle_steering #(
  parameter int TIMER_WIDTH = 16
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  urs_in_if.sink                              in_chan,
  urs_out_if.source                           out_chan,
  input  wire logic                           cfg_we,
  input  wire logic [urs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [urs_pkg::DIST_W-1:0]     cfg_data
);

  // Input register.
  logic                       in_valid_r;
  logic                       in_mode_r;
  logic [urs_pkg::CAP_W-1:0]  in_cap_r;

  // Result register.
  logic                       out_valid_r;
  urs_pkg::result_t           out_res_r;

  urs_pkg::cfg_t              cfg_r;
  urs_pkg::echo_evt_t         evt;
  urs_pkg::result_t           res_nxt;
  logic                       step;

  // Advance the held request when the result register is free or draining.
  assign step         = in_valid_r && (!out_valid_r || out_chan.ready);
  assign in_chan.ready = !in_valid_r || step;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_chan.ready) begin
      in_valid_r <= in_chan.valid;
    end
  end

  // Payload needs no reset; load only on acceptance.
  always_ff @(posedge clk) begin
    if (in_chan.valid && in_chan.ready) begin
      in_mode_r <= in_chan.mode;
      in_cap_r  <= in_chan.capture_time;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.front_thr <= urs_pkg::FRONT_THR_RST;
      cfg_r.side_thr  <= urs_pkg::SIDE_THR_RST;
      cfg_r.turn_thr  <= urs_pkg::TURN_THR_RST;
      cfg_r.side_marg <= urs_pkg::SIDE_MARG_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        urs_pkg::CFG_FRONT_THR: cfg_r.front_thr <= cfg_data;
        urs_pkg::CFG_SIDE_THR:  cfg_r.side_thr  <= cfg_data;
        urs_pkg::CFG_TURN_THR:  cfg_r.turn_thr  <= cfg_data;
        urs_pkg::CFG_SIDE_MARG: cfg_r.side_marg <= cfg_data;
        default: ;
      endcase
    end
  end

  urs_ranger #(
    .TIMER_WIDTH (TIMER_WIDTH)
  ) u_ranger (
    .clk          (clk),
    .rst_n        (rst_n),
    .step         (step),
    .mode         (in_mode_r),
    .capture_time (in_cap_r),
    .evt          (evt)
  );

  urs_steer u_steer (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step),
    .evt   (evt),
    .cfg   (cfg_r),
    .res   (res_nxt)
  );

  // Hold the result until the receiver takes it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_res_r <= res_nxt;
    end
  end

  assign out_chan.valid               = out_valid_r;
  assign out_chan.trigger_pulse       = out_res_r.trigger_pulse;
  assign out_chan.sensor_select       = out_res_r.sensor_select;
  assign out_chan.left_wheel_reverse  = out_res_r.left_wheel_reverse;
  assign out_chan.right_wheel_reverse = out_res_r.right_wheel_reverse;
  assign out_chan.drive_mode          = out_res_r.drive_mode;
  assign out_chan.front_range         = out_res_r.front_range;
  assign out_chan.left_range          = out_res_r.left_range;
  assign out_chan.right_range         = out_res_r.right_range;

`ifndef NO_ASSERTIONS
  // A held request that cannot advance stays in the input register.
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r && !step |=> in_valid_r)
    else $error("input request dropped while stalled");

  // Every advanced request shows up as a result.
  a_step_result: assert property (@(posedge clk) disable iff (!rst_n)
    step |=> out_valid_r)
    else $error("advanced request produced no result");

  // A taken result with nothing behind it empties the result register.
  a_out_drain: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_chan.ready && !step |=> !out_valid_r)
    else $error("result repeated after it was taken");

  // A stalled result keeps its payload.
  a_out_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_chan.ready |=> out_valid_r && $stable(out_res_r))
    else $error("stalled result changed");
`endif

endmodule
`default_nettype wire
